[hw/rtl/sahit_pkg.sv]
// Shared constants for the segment/box hit test core.
// No dependencies; imported by every module under hw/rtl except sahit_checker.
package sahit_pkg;

    // Result bits resolved per pipeline stage in the root and divide units
    localparam int SAHIT_BPS = 2;

    // Epsilon in raw Q16.16 units and the fraction width of the format
    localparam int SEG_EPS   = 7;
    localparam int FRAC_BITS = 16;

    // Configuration register map
    localparam int CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_START_X = 2'd0,
        CFG_START_Y = 2'd1,
        CFG_START_Z = 2'd2
    } t_cfg_idx;

endpackage

[hw/rtl/segment_aabb_hit_test_core.sv]
// Segment versus axis-aligned box hit test, signed Q16.16 slab method.
// Depends on sahit_pkg, sahit_sqrt and sahit_div.
// Throughput: one transaction per cycle unless a held result stalls the pipe; the root
// and divide units resolve two bits per stage and every stage advances together.
// Reset (synchronous, active low) clears the start point and all valid bits.
module segment_aabb_hit_test_core #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // configuration
    input  logic                                    i_cfg_wr_en,
    input  logic [sahit_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                  i_cfg_data,
    // input channel
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [COORD_WIDTH-1:0]           i_end_x,
    input  logic signed [COORD_WIDTH-1:0]           i_end_y,
    input  logic signed [COORD_WIDTH-1:0]           i_end_z,
    input  logic signed [COORD_WIDTH-1:0]           i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0]           i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0]           i_box_min_z,
    input  logic signed [COORD_WIDTH-1:0]           i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0]           i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0]           i_box_max_z,
    input  logic [COORD_WIDTH-2:0]                  i_max_distance,
    // output channel
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_hit
);
    import sahit_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;          // end - start, bound - start
    localparam int LW   = W + 1;          // segment length
    localparam int SW   = 2 * DW;         // squared lengths
    localparam int NW   = DW + LW;        // |bound - start| * length
    localparam int QW   = W + 2;          // saturated quotient magnitude
    localparam int TW   = QW + 1;         // signed slab parameter
    localparam int MDW  = W - 1;          // distance limit
    localparam int PW   = DW + FRAC_BITS; // parallel-axis compare
    localparam int SQ_LAT  = (LW + SAHIT_BPS - 1) / SAHIT_BPS;
    localparam int DIV_LAT = 1 + (QW + SAHIT_BPS - 1) / SAHIT_BPS;
    localparam int VLEN    = 4 + SQ_LAT + 1 + DIV_LAT + 3;

    // Sideband that rides next to the square root
    typedef struct packed {
        logic [2:0][DW-1:0] ad;      // |end - start| per axis
        logic [5:0]         neg;     // sign of each slab quotient
        logic [5:0][DW-1:0] an;      // |bound - start|, min then max per axis
        logic [2:0]         inslab;  // start lies in [min, max]
        logic [MDW-1:0]     maxd;
    } t_sq_side;

    // Sideband that rides next to the dividers
    typedef struct packed {
        logic [5:0]     neg;
        logic [2:0]     par;         // axis treated as parallel
        logic [2:0]     inslab;
        logic           seg_short;   // length or limit at most epsilon
        logic [LW-1:0]  tmax0;       // min(length, limit)
        logic [MDW-1:0] maxd;
    } t_div_side;

    function automatic logic [DW-1:0] f_mag(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: every stage advances unless the result is held
    // ------------------------------------------------------------------
    logic            w_en;
    logic [VLEN-1:0] r_vld;

    assign w_en    = !(r_vld[VLEN-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[VLEN-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VLEN-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Configuration: segment start point
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_start_x, r_start_y, r_start_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_START_X: r_start_x <= i_cfg_data;
                CFG_START_Y: r_start_y <= i_cfg_data;
                CFG_START_Z: r_start_z <= i_cfg_data;
                default: ;   // drop writes beyond the register map
            endcase
        end
    end

    logic signed [W-1:0] w_start [3];
    logic signed [W-1:0] w_end   [3];
    logic signed [W-1:0] w_bmin  [3];
    logic signed [W-1:0] w_bmax  [3];

    assign w_start = '{r_start_x, r_start_y, r_start_z};
    assign w_end   = '{i_end_x, i_end_y, i_end_z};
    assign w_bmin  = '{i_box_min_x, i_box_min_y, i_box_min_z};
    assign w_bmax  = '{i_box_max_x, i_box_max_y, i_box_max_z};

    // ------------------------------------------------------------------
    // Stages 1..4: differences, magnitudes, squares, sum of squares
    // ------------------------------------------------------------------
    logic signed [DW-1:0] r1_d   [3];
    logic signed [DW-1:0] r1_nlo [3];
    logic signed [DW-1:0] r1_nhi [3];
    logic [2:0]           r1_inslab;
    logic [MDW-1:0]       r1_maxd;

    logic [DW-1:0]        r2_ad [3];
    logic [DW-1:0]        r2_an [6];
    logic [5:0]           r2_neg;
    logic [2:0]           r2_inslab;
    logic [MDW-1:0]       r2_maxd;

    logic [SW-1:0]        r3_sq [3];
    t_sq_side             r3_side;

    logic [SW-1:0]        r4_sum;
    t_sq_side             r4_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int a = 0; a < 3; a++) begin
                r1_d[a]      <= {w_end[a][W-1], w_end[a]} - {w_start[a][W-1], w_start[a]};
                r1_nlo[a]    <= {w_bmin[a][W-1], w_bmin[a]} - {w_start[a][W-1], w_start[a]};
                r1_nhi[a]    <= {w_bmax[a][W-1], w_bmax[a]} - {w_start[a][W-1], w_start[a]};
                r1_inslab[a] <= (w_start[a] >= w_bmin[a]) && (w_start[a] <= w_bmax[a]);
            end
            r1_maxd <= i_max_distance;

            // split into magnitude and sign
            for (int a = 0; a < 3; a++) begin
                r2_ad[a]       <= f_mag(r1_d[a]);
                r2_an[2*a]     <= f_mag(r1_nlo[a]);
                r2_an[2*a+1]   <= f_mag(r1_nhi[a]);
                r2_neg[2*a]    <= r1_d[a][DW-1] ^ r1_nlo[a][DW-1];
                r2_neg[2*a+1]  <= r1_d[a][DW-1] ^ r1_nhi[a][DW-1];
            end
            r2_inslab <= r1_inslab;
            r2_maxd   <= r1_maxd;

            for (int a = 0; a < 3; a++) begin
                r3_sq[a]         <= SW'(r2_ad[a]) * SW'(r2_ad[a]);
                r3_side.ad[a]    <= r2_ad[a];
            end
            for (int i = 0; i < 6; i++) begin
                r3_side.an[i] <= r2_an[i];
            end
            r3_side.neg    <= r2_neg;
            r3_side.inslab <= r2_inslab;
            r3_side.maxd   <= r2_maxd;

            r4_sum  <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            r4_side <= r3_side;
        end
    end

    // ------------------------------------------------------------------
    // Segment length: floor(sqrt(sum)), Q32.32 in, Q16.16 out
    // ------------------------------------------------------------------
    logic [LW-1:0] w_len;
    t_sq_side      r_sqd [SQ_LAT];
    t_sq_side      w_sq_side;

    sahit_sqrt #(
        .ROOT_WIDTH (LW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_sum),
        .o_root (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqd[0] <= r4_side;
            for (int i = 1; i < SQ_LAT; i++) begin
                r_sqd[i] <= r_sqd[i-1];
            end
        end
    end

    assign w_sq_side = r_sqd[SQ_LAT-1];

    // ------------------------------------------------------------------
    // Product stage: numerators, parallel test, early-out flags
    // ------------------------------------------------------------------
    logic [NW-1:0] r_p_num [6];
    logic [DW-1:0] r_p_den [3];
    t_div_side     r_p_side;
    t_div_side     n_p_side;

    always_comb begin
        logic [PW-1:0] v_lhs;
        logic [PW-1:0] v_rhs;
        for (int a = 0; a < 3; a++) begin
            // parallel when |d| * 2^16 < eps * L
            v_lhs         = PW'(w_sq_side.ad[a]) << FRAC_BITS;
            v_rhs         = PW'(w_len) * PW'(SEG_EPS);
            n_p_side.par[a] = (v_rhs > v_lhs);
        end
        n_p_side.neg       = w_sq_side.neg;
        n_p_side.inslab    = w_sq_side.inslab;
        n_p_side.seg_short = (w_len <= LW'(SEG_EPS)) || (w_sq_side.maxd <= MDW'(SEG_EPS));
        n_p_side.tmax0     = (LW'(w_sq_side.maxd) < w_len) ? LW'(w_sq_side.maxd) : w_len;
        n_p_side.maxd      = w_sq_side.maxd;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 6; i++) begin
                r_p_num[i] <= NW'(w_sq_side.an[i]) * NW'(w_len);
            end
            for (int a = 0; a < 3; a++) begin
                r_p_den[a] <= w_sq_side.ad[a];
            end
            r_p_side <= n_p_side;
        end
    end

    // ------------------------------------------------------------------
    // Slab quotients: |bound - start| * L / |d|, saturated
    // ------------------------------------------------------------------
    logic [QW-1:0] w_quo [6];
    t_div_side     r_dvd [DIV_LAT];
    t_div_side     w_dv_side;

    for (genvar g = 0; g < 6; g++) begin : g_div
        sahit_div #(
            .NUM_WIDTH (NW),
            .DEN_WIDTH (DW),
            .QUO_WIDTH (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_p_num[g]),
            .i_den (r_p_den[g/2]),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dvd[0] <= r_p_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dvd[i] <= r_dvd[i-1];
            end
        end
    end

    assign w_dv_side = r_dvd[DIV_LAT-1];

    // ------------------------------------------------------------------
    // Stage A: apply signs and order entry/exit per axis
    // ------------------------------------------------------------------
    logic signed [TW-1:0] r_a_lo [3];
    logic signed [TW-1:0] r_a_hi [3];
    t_div_side            r_a_side;
    logic signed [TW-1:0] n_a_lo [3];
    logic signed [TW-1:0] n_a_hi [3];

    always_comb begin
        logic signed [TW-1:0] v_t1;
        logic signed [TW-1:0] v_t2;
        for (int a = 0; a < 3; a++) begin
            v_t1 = TW'(w_quo[2*a]);
            v_t2 = TW'(w_quo[2*a+1]);
            if (w_dv_side.neg[2*a]) begin
                v_t1 = -v_t1;
            end
            if (w_dv_side.neg[2*a+1]) begin
                v_t2 = -v_t2;
            end
            n_a_lo[a] = (v_t1 > v_t2) ? v_t2 : v_t1;
            n_a_hi[a] = (v_t1 > v_t2) ? v_t1 : v_t2;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: narrow [0, min(L, limit)] by the non-parallel slabs
    // ------------------------------------------------------------------
    logic signed [TW-1:0] r_b_tmin;
    logic signed [TW-1:0] r_b_tmax;
    logic                 r_b_ok;
    logic [MDW-1:0]       r_b_maxd;
    logic signed [TW-1:0] n_b_tmin;
    logic signed [TW-1:0] n_b_tmax;

    always_comb begin
        n_b_tmin = '0;
        n_b_tmax = TW'(r_a_side.tmax0);
        for (int a = 0; a < 3; a++) begin
            if (!r_a_side.par[a]) begin
                if (r_a_lo[a] > n_b_tmin) begin
                    n_b_tmin = r_a_lo[a];
                end
                if (r_a_hi[a] < n_b_tmax) begin
                    n_b_tmax = r_a_hi[a];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: final interval checks into the result register
    // ------------------------------------------------------------------
    logic                 r_hit;
    logic signed [TW-1:0] w_b_maxd;

    assign w_b_maxd = TW'(r_b_maxd);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_lo   <= n_a_lo;
            r_a_hi   <= n_a_hi;
            r_a_side <= w_dv_side;

            r_b_tmin <= n_b_tmin;
            r_b_tmax <= n_b_tmax;
            // a parallel axis needs the start inside its slab
            r_b_ok   <= !r_a_side.seg_short && (&(~r_a_side.par | r_a_side.inslab));
            r_b_maxd <= r_a_side.maxd;

            r_hit <= r_b_ok && (r_b_tmin <= r_b_tmax) && (r_b_tmax >= 0)
                     && (r_b_tmin <= w_b_maxd);
        end
    end

    assign o_hit = r_hit;

endmodule

[hw/rtl/sahit_sqrt.sv]
// Pipelined integer square root, SAHIT_BPS root bits per register stage.
// Depends on sahit_pkg.
module sahit_sqrt #(
    parameter int ROOT_WIDTH = 33
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [2*ROOT_WIDTH-1:0] i_rad,
    output logic [ROOT_WIDTH-1:0]   o_root
);
    import sahit_pkg::*;

    localparam int RADW = 2 * ROOT_WIDTH;
    localparam int REMW = ROOT_WIDTH + 2;
    localparam int NST  = (ROOT_WIDTH + SAHIT_BPS - 1) / SAHIT_BPS;

    logic [RADW-1:0]       r_rad  [NST];
    logic [REMW-1:0]       r_rem  [NST];
    logic [ROOT_WIDTH-1:0] r_root [NST];

    logic [RADW-1:0]       n_rad  [NST];
    logic [REMW-1:0]       n_rem  [NST];
    logic [ROOT_WIDTH-1:0] n_root [NST];

    logic [RADW-1:0]       w_rad_in  [NST];
    logic [REMW-1:0]       w_rem_in  [NST];
    logic [ROOT_WIDTH-1:0] w_root_in [NST];

    always_comb begin
        w_rad_in[0]  = i_rad;
        w_rem_in[0]  = '0;
        w_root_in[0] = '0;
        for (int s = 1; s < NST; s++) begin
            w_rad_in[s]  = r_rad[s-1];
            w_rem_in[s]  = r_rem[s-1];
            w_root_in[s] = r_root[s-1];
        end
    end

    always_comb begin
        logic [RADW-1:0]       v_rad;
        logic [REMW-1:0]       v_rem;
        logic [REMW-1:0]       v_try;
        logic [REMW-1:0]       v_trial;
        logic [ROOT_WIDTH-1:0] v_root;
        for (int s = 0; s < NST; s++) begin
            v_rad  = w_rad_in[s];
            v_rem  = w_rem_in[s];
            v_root = w_root_in[s];
            for (int k = 0; k < SAHIT_BPS; k++) begin
                if (s * SAHIT_BPS + k < ROOT_WIDTH) begin
                    // bring down the next radicand pair, try root*4+1
                    v_try   = {v_rem[REMW-3:0], v_rad[RADW-1 -: 2]};
                    v_trial = {v_root, 2'b01};
                    if (v_try >= v_trial) begin
                        v_rem  = v_try - v_trial;
                        v_root = {v_root[ROOT_WIDTH-2:0], 1'b1};
                    end else begin
                        v_rem  = v_try;
                        v_root = {v_root[ROOT_WIDTH-2:0], 1'b0};
                    end
                    v_rad = v_rad << 2;
                end
            end
            n_rad[s]  = v_rad;
            n_rem[s]  = v_rem;
            n_root[s] = v_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_rad[s]  <= n_rad[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_root = r_root[NST-1];

endmodule

[hw/rtl/sahit_div.sv]
// Pipelined restoring divider with a saturating quotient.
// Depends on sahit_pkg.
module sahit_div #(
    parameter int NUM_WIDTH = 66,
    parameter int DEN_WIDTH = 33,
    parameter int QUO_WIDTH = 34
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DEN_WIDTH-1:0] i_den,
    output logic [QUO_WIDTH-1:0] o_quo
);
    import sahit_pkg::*;

    localparam int HIW = NUM_WIDTH - QUO_WIDTH;
    localparam int NST = (QUO_WIDTH + SAHIT_BPS - 1) / SAHIT_BPS;

    // entry stage: overflow check and initial partial remainder
    logic                 r_ovf0;
    logic [DEN_WIDTH-1:0] r_rem0;
    logic [QUO_WIDTH-1:0] r_low0;
    logic [DEN_WIDTH-1:0] r_den0;

    logic                 r_ovf [NST];
    logic [DEN_WIDTH-1:0] r_rem [NST];
    logic [QUO_WIDTH-1:0] r_low [NST];
    logic [QUO_WIDTH-1:0] r_quo [NST];
    logic [DEN_WIDTH-1:0] r_den [NST];

    logic [DEN_WIDTH-1:0] n_rem [NST];
    logic [QUO_WIDTH-1:0] n_low [NST];
    logic [QUO_WIDTH-1:0] n_quo [NST];

    logic [DEN_WIDTH-1:0] w_rem_in [NST];
    logic [QUO_WIDTH-1:0] w_low_in [NST];
    logic [QUO_WIDTH-1:0] w_quo_in [NST];
    logic [DEN_WIDTH-1:0] w_den_in [NST];
    logic                 w_ovf_in [NST];
    logic [DEN_WIDTH-1:0] w_hi;

    assign w_hi = DEN_WIDTH'(i_num[NUM_WIDTH-1 -: HIW]);

    always_comb begin
        w_rem_in[0] = r_rem0;
        w_low_in[0] = r_low0;
        w_quo_in[0] = '0;
        w_den_in[0] = r_den0;
        w_ovf_in[0] = r_ovf0;
        for (int s = 1; s < NST; s++) begin
            w_rem_in[s] = r_rem[s-1];
            w_low_in[s] = r_low[s-1];
            w_quo_in[s] = r_quo[s-1];
            w_den_in[s] = r_den[s-1];
            w_ovf_in[s] = r_ovf[s-1];
        end
    end

    always_comb begin
        logic [DEN_WIDTH:0]   v_try;
        logic [DEN_WIDTH-1:0] v_rem;
        logic [QUO_WIDTH-1:0] v_low;
        logic [QUO_WIDTH-1:0] v_quo;
        for (int s = 0; s < NST; s++) begin
            v_rem = w_rem_in[s];
            v_low = w_low_in[s];
            v_quo = w_quo_in[s];
            for (int k = 0; k < SAHIT_BPS; k++) begin
                if (s * SAHIT_BPS + k < QUO_WIDTH) begin
                    v_try = {v_rem, v_low[QUO_WIDTH-1]};
                    if (v_try >= {1'b0, w_den_in[s]}) begin
                        v_rem = DEN_WIDTH'(v_try - {1'b0, w_den_in[s]});
                        v_quo = {v_quo[QUO_WIDTH-2:0], 1'b1};
                    end else begin
                        v_rem = DEN_WIDTH'(v_try);
                        v_quo = {v_quo[QUO_WIDTH-2:0], 1'b0};
                    end
                    v_low = v_low << 1;
                end
            end
            n_rem[s] = v_rem;
            n_low[s] = v_low;
            n_quo[s] = v_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // quotient does not fit when the top bits already reach the divisor
            r_ovf0 <= (w_hi >= i_den);
            r_rem0 <= w_hi;
            r_low0 <= i_num[QUO_WIDTH-1:0];
            r_den0 <= i_den;
            for (int s = 0; s < NST; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= w_den_in[s];
                r_ovf[s] <= w_ovf_in[s];
            end
        end
    end

    assign o_quo = r_ovf[NST-1] ? '1 : r_quo[NST-1];

endmodule

[hw/rtl/sahit_checker.sv]
// Port-level assertions for segment_aabb_hit_test_core, attached by bind.
// Depends on the top level's port list only.
module sahit_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_stall,
    input logic i_out_valid,
    input logic i_out_stall,
    input logic i_hit
);

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk)
        i_in_stall |-> (i_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // the input side never stalls while no result is pending on the output side
    a_no_idle_stall: assert property (@(posedge i_clk)
        !i_out_valid |-> !i_in_stall)
        else $error("input stalled with no pending result");

    // reset empties the pipeline
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_hit)))
        else $error("stalled result changed");

    // an input offered while stalled leaves the output valid unchanged
    a_accept_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_stall) |=> $stable(i_out_valid))
        else $error("pipeline advanced under stall");

endmodule

bind segment_aabb_hit_test_core sahit_checker u_sahit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_hit       (o_hit)
);

[test/tb.sv]
// Self-checking testbench for segment_aabb_hit_test_core: a slab-test predictor
// in a small scoreboard class, random and directed transactions, random stalls.
// Depends on sahit_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;
    import sahit_pkg::*;

    localparam int CW       = 32;
    localparam int LATENCY  = CW + 11;
    localparam int N_RANDOM = 1900;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint T_SAT = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic signed [CW-1:0] end_pt  [3];
        logic signed [CW-1:0] box_min [3];
        logic signed [CW-1:0] box_max [3];
        logic [CW-2:0]        max_dist;
    } t_seg_box;

    int error_count = 0;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] ERROR: %s", $time, what);
    endtask

    // Predicts the hit flag of each transaction and keeps the expected flags in order.
    class hit_scoreboard;
        logic signed [CW-1:0] start_pt [3];
        bit pending_hits [$];

        function new();
            for (int a = 0; a < 3; a++) start_pt[a] = '0;
        endfunction

        function void set_start(t_cfg_idx idx, logic [CW-1:0] value);
            start_pt[int'(idx)] = value;
        endfunction

        // Square root of a 128-bit value, floored.
        function automatic logic [63:0] isqrt(logic [127:0] s);
            logic [63:0] res;
            logic [63:0] c;
            res = '0;
            for (int b = 63; b >= 0; b--) begin
                c = res | (64'd1 << b);
                if ({64'd0, c} * {64'd0, c} <= s) res = c;
            end
            return res;
        endfunction

        // Entry/exit parameter (num * len / d), magnitude truncated and saturated.
        function automatic longint slab_param(longint num, logic [63:0] len, longint d);
            logic [127:0] prod;
            logic [63:0]  an, ad;
            logic [127:0] q;
            an   = num < 0 ? -num : num;
            ad   = d < 0 ? -d : d;
            prod = {64'd0, an} * {64'd0, len};
            q    = prod / {64'd0, ad};
            if (q > T_SAT) q = T_SAT;
            return ((num < 0) != (d < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function automatic bit predict_hit(t_seg_box it);
            longint d [3];
            longint s, lo, hi, t1, t2, tt, tmin, tmax;
            logic [127:0] sum;
            logic [63:0] len, ad, maxd;
            sum = '0;
            for (int a = 0; a < 3; a++) begin
                d[a] = longint'(it.end_pt[a]) - longint'(start_pt[a]);
                ad   = d[a] < 0 ? -d[a] : d[a];
                sum += {64'd0, ad} * {64'd0, ad};
            end
            len  = isqrt(sum);
            maxd = {33'd0, it.max_dist};
            if (len <= SEG_EPS || maxd <= SEG_EPS) return 0;
            tmin = 0;
            tmax = len < maxd ? len : maxd;
            for (int a = 0; a < 3; a++) begin
                s  = start_pt[a];
                lo = it.box_min[a];
                hi = it.box_max[a];
                ad = d[a] < 0 ? -d[a] : d[a];
                // parallel axis: start must sit inside the slab
                if ({64'd0, ad} << FRAC_BITS < 128'(SEG_EPS) * {64'd0, len}) begin
                    if (s < lo || s > hi) return 0;
                    continue;
                end
                t1 = slab_param(lo - s, len, d[a]);
                t2 = slab_param(hi - s, len, d[a]);
                if (t1 > t2) begin tt = t1; t1 = t2; t2 = tt; end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) return 0;
            end
            return (tmax >= 0 && tmin <= longint'(maxd));
        endfunction

        function void note_input(t_seg_box it);
            pending_hits.push_back(predict_hit(it));
        endfunction

        task check_result(bit got);
            bit want;
            if (pending_hits.size() == 0) begin
                report_mismatch($sformatf("unexpected result hit=%0b", got));
                return;
            end
            want = pending_hits.pop_front();
            if (got !== want)
                report_mismatch($sformatf("hit: got %0b, want %0b", got, want));
        endtask
    endclass

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            i_cfg_wr_en = 0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CW-1:0]   i_cfg_data = '0;
    logic            i_valid = 0;
    logic            o_stall;
    logic signed [CW-1:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic signed [CW-1:0] i_box_min_x = '0, i_box_min_y = '0, i_box_min_z = '0;
    logic signed [CW-1:0] i_box_max_x = '0, i_box_max_y = '0, i_box_max_z = '0;
    logic [CW-2:0]   i_max_distance = '0;
    logic            o_valid;
    logic            i_stall = 0;
    logic            o_hit;

    hit_scoreboard sb = new();
    longint cycle_count = 0;
    bit     hold_off_req = 0;   // receiver long hold-off request
    bit     no_idle = 0;        // stretch with no idling on either side

    segment_aabb_hit_test_core #(.COORD_WIDTH(CW)) DUT (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog: end the run if it never drains.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[%0t] ERROR: timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Check each result transaction at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_hit);
    end

    // Receiver: random stall, plus a long hold-off on request, counted here.
    initial begin
        int held;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall <= 1;
                for (held = 0; held < 150; held++) @(negedge i_clk);
                hold_off_req = 0;
            end
            i_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 18);
        end
    end

    task automatic write_cfg(t_cfg_idx idx, logic [CW-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        sb.set_start(idx, value);
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
    endtask

    task automatic set_start_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        write_cfg(CFG_START_X, x);
        write_cfg(CFG_START_Y, y);
        write_cfg(CFG_START_Z, z);
    endtask

    // Offer one transaction; called at a falling edge, returns at a falling edge.
    task automatic send_item(t_seg_box it);
        while (!no_idle && $urandom_range(99) < 18) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        {i_end_x, i_end_y, i_end_z}             <= {it.end_pt[0], it.end_pt[1], it.end_pt[2]};
        {i_box_min_x, i_box_min_y, i_box_min_z} <= {it.box_min[0], it.box_min[1], it.box_min[2]};
        {i_box_max_x, i_box_max_y, i_box_max_z} <= {it.box_max[0], it.box_max[1], it.box_max[2]};
        i_max_distance <= it.max_dist;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending_hits.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rnd_word();
        return $urandom();
    endfunction

    // Coordinate near the start point or fully random; keeps boxes hittable.
    function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] c, int span);
        return (span == 0) ? rnd_word() : c + $signed($urandom_range(2 * span) - span);
    endfunction

    function automatic t_seg_box random_item();
        t_seg_box it;
        int span;
        logic signed [CW-1:0] p, q;
        span = ($urandom_range(9) == 0) ? 0 : (1 << $urandom_range(22, 4));
        for (int a = 0; a < 3; a++) begin
            it.end_pt[a] = near(sb.start_pt[a], span);
            if ($urandom_range(9) == 0) it.end_pt[a] = sb.start_pt[a] + $urandom_range(4);
            p = near(sb.start_pt[a], span);
            q = near(sb.start_pt[a], span);
            // mostly well-ordered boxes, some inverted
            if ($urandom_range(9) != 0 && p > q) begin it.box_min[a] = q; it.box_max[a] = p; end
            else begin it.box_min[a] = p; it.box_max[a] = q; end
        end
        case ($urandom_range(5))
            0:       it.max_dist = (CW-1)'($urandom_range(10));
            1:       it.max_dist = (CW-1)'(rnd_word());
            default: it.max_dist = (CW-1)'($urandom_range(4 * span + 64));
        endcase
        return it;
    endfunction

    function automatic t_seg_box make_item(logic signed [CW-1:0] e, logic signed [CW-1:0] lo,
                                           logic signed [CW-1:0] hi, logic [CW-2:0] md);
        t_seg_box it;
        for (int a = 0; a < 3; a++) begin
            it.end_pt[a] = e; it.box_min[a] = lo; it.box_max[a] = hi;
        end
        it.max_dist = md;
        return it;
    endfunction

    initial begin
        t_seg_box it;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: start at origin after reset.
        no_idle = 1;
        send_item(make_item(32'sh0010_0000, 32'sh0002_0000, 32'sh0004_0000, 31'h7FFF_FFFF));
        send_item(make_item(32'sh0010_0000, 32'sh0002_0000, 32'sh0004_0000, 31'h0000_0007));
        send_item(make_item(32'sh0010_0000, 32'sh0002_0000, 32'sh0004_0000, 31'h0000_0008));
        send_item(make_item(32'sh0000_0003, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(make_item(32'sh0000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(make_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(make_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0001, 31'h7FFF_FFFF));
        // inverted box
        send_item(make_item(32'sh0010_0000, 32'sh0004_0000, 32'sh0002_0000, 31'h7FFF_FFFF));
        // parallel axes: move along x only
        it = make_item(0, 32'shFFFF_0000, 32'sh0001_0000, 31'h7FFF_FFFF);
        it.end_pt[0] = 32'sh0020_0000;
        send_item(it);
        it.box_min[1] = 32'sh0000_0001;
        send_item(it);
        it.end_pt[1] = 32'sh0000_0001;  // tiny off-axis component
        send_item(it);
        // box behind the start
        send_item(make_item(32'sh0010_0000, 32'shFFF0_0000, 32'shFFF8_0000, 31'h7FFF_FFFF));
        drain();

        // Extreme start points: saturating quotients and full-range differences.
        set_start_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(make_item(32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001, 31'h7FFF_FFFF));
        send_item(make_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(make_item(32'sh8000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF));
        drain();
        set_start_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(make_item(32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0001, 31'h7FFF_FFFF));
        send_item(make_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h0000_0008));
        drain();
        no_idle = 0;

        // Random phases over several start points; one pressure test per phase kind.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) set_start_point(0, 0, 0);
            else set_start_point(rnd_word(), rnd_word() >>> $urandom_range(31),
                                 $urandom_range(1) ? rnd_word() : 32'h0);
            no_idle = (ph == 2);
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                if (ph == 3 && n == 20) hold_off_req = 1;   // fill the pipe
                if (ph == 5 && n == 100) begin               // sender pause until empty
                    i_valid <= 0;
                    while (sb.pending_hits.size() != 0) @(negedge i_clk);
                end
                send_item(random_item());
            end
            drain();
        end

        if (error_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
